/* rtl/ctlm_pkg.sv */
// ----------------------------------------------------------------------------
// ctlm_pkg: task list manager shared definitions
// Sizes, request and result types, and the link memory slot mapping.
// ----------------------------------------------------------------------------
package ctlm_pkg;

    localparam int TASKS      = 32;
    localparam int QUEUES     = 5;
    localparam int TASK_W     = 5;
    localparam int QSEL_W     = 3;
    localparam int CNT_W      = $clog2(TASKS + 1);
    localparam int LINK_DEPTH = QUEUES * TASKS;
    localparam int SLOT_W     = $clog2(LINK_DEPTH);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic              ok;
        logic [CNT_W-1:0]  count_after;
        logic [TASK_W-1:0] head_task;
        logic              head_valid;
    } rsp_t;

    function automatic logic [SLOT_W-1:0] slot(input logic [QSEL_W-1:0] q,
                                               input logic [TASK_W-1:0] t);
        return SLOT_W'(q) * SLOT_W'(TASKS) + SLOT_W'(t);
    endfunction

endpackage

/* rtl/ctlm_req_if.sv */
// ----------------------------------------------------------------------------
// ctlm_req_if: request channel
// Valid/ready channel carrying one queue insert or remove request.
// ----------------------------------------------------------------------------
interface ctlm_req_if;
    import ctlm_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [QSEL_W-1:0] queue_sel;
    logic [TASK_W-1:0] task_id;

    modport source (output valid, output req_type, output queue_sel, output task_id,
                    input ready);
    modport sink   (input valid, input req_type, input queue_sel, input task_id,
                    output ready);
endinterface

/* rtl/ctlm_rsp_if.sv */
// ----------------------------------------------------------------------------
// ctlm_rsp_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface ctlm_rsp_if;
    import ctlm_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [CNT_W-1:0]  count_after;
    logic [TASK_W-1:0] head_task;
    logic              head_valid;

    modport source (output valid, output ok, output count_after, output head_task,
                    output head_valid, input ready);
    modport sink   (input valid, input ok, input count_after, input head_task,
                    input head_valid, output ready);
endinterface

/* rtl/circular_task_list_manager.sv */
// ----------------------------------------------------------------------------
// circular_task_list_manager: circular doubly linked task queue manager
// Flow: a request goes from the execute state, and for an insert into a
//   nonempty queue a second write state (the single write port of each link
//   RAM), to the output register, waiting in the finish state on a stall.
// Requests: taken only when idle, so a new one waits for the last to finish.
// Reset: membership and counts clear at once; link RAMs are not cleared.
// ----------------------------------------------------------------------------
module circular_task_list_manager (
    input  logic       clk,
    input  logic       rst_n,
    ctlm_req_if.sink   req,
    ctlm_rsp_if.source rsp
);
    import ctlm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;

    logic [QUEUES-1:0] member_reg [TASKS];
    logic [CNT_W-1:0]  count_reg  [QUEUES];
    logic [TASK_W-1:0] head_reg   [QUEUES];

    logic              req_type_reg;
    logic [QSEL_W-1:0] req_q_reg;
    logic [TASK_W-1:0] req_task_reg;
    logic              req_qv_reg;
    logic [QUEUES-1:0] req_mem_reg;
    logic [CNT_W-1:0]  req_cnt_reg;
    logic [TASK_W-1:0] req_head_reg;
    logic [TASK_W-1:0] tail_reg;
    rsp_t              res_reg;

    logic              accept;
    logic              in_qv;
    logic [TASK_W-1:0] in_head;
    logic              tv;
    logic              is_mem;
    logic              do_ins;
    logic              do_rem;
    logic              need_wr2;
    logic [CNT_W-1:0]  cnt_new;
    logic [TASK_W-1:0] head_new;
    rsp_t              res_now;
    rsp_t              ld_data;
    logic              ld;
    logic              stall;

    logic              nx_we;
    logic [SLOT_W-1:0] nx_waddr;
    logic [TASK_W-1:0] nx_wdata;
    logic [SLOT_W-1:0] nx_raddr;
    logic [TASK_W-1:0] nx_rdata;
    logic              pv_we;
    logic [SLOT_W-1:0] pv_waddr;
    logic [TASK_W-1:0] pv_wdata;
    logic [SLOT_W-1:0] pv_raddr;
    logic [TASK_W-1:0] pv_rdata;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_qv     = (32'(req.queue_sel) < QUEUES);
    assign in_head   = in_qv ? head_reg[req.queue_sel] : '0;

    // read own links on remove, the head's prev link on insert
    assign nx_raddr = slot(req.queue_sel, req.task_id);
    assign pv_raddr = (req.req_type == REQ_REMOVE) ? slot(req.queue_sel, req.task_id)
                                                   : slot(req.queue_sel, in_head);

    ctlm_ram #(.WIDTH(TASK_W), .DEPTH(LINK_DEPTH)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (accept),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    ctlm_ram #(.WIDTH(TASK_W), .DEPTH(LINK_DEPTH)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (accept),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    assign tv       = (32'(req_task_reg) < TASKS);
    assign is_mem   = req_qv_reg ? req_mem_reg[req_q_reg] : 1'b0;
    assign do_ins   = req_qv_reg && tv && (req_type_reg == REQ_INSERT) && !is_mem;
    assign do_rem   = req_qv_reg && tv && (req_type_reg == REQ_REMOVE) && is_mem;
    assign need_wr2 = do_ins && (req_cnt_reg != '0);

    always_comb
    begin
        cnt_new  = req_cnt_reg;
        head_new = req_head_reg;
        if (do_ins)
        begin
            cnt_new = req_cnt_reg + CNT_W'(1);
            if (req_cnt_reg == '0)
            begin
                head_new = req_task_reg;
            end
        end
        else if (do_rem)
        begin
            cnt_new = req_cnt_reg - CNT_W'(1);
            if (req_head_reg == req_task_reg)
            begin
                head_new = nx_rdata;
            end
        end
    end

    always_comb
    begin
        res_now.ok          = do_ins || do_rem;
        res_now.count_after = req_qv_reg ? cnt_new : '0;
        res_now.head_valid  = req_qv_reg && (cnt_new != '0);
        res_now.head_task   = res_now.head_valid ? head_new : '0;
    end

    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = '0;
        case (state_reg)
            S_EXEC:
            begin
                if (do_ins)
                begin
                    nx_we    = 1'b1;
                    pv_we    = 1'b1;
                    nx_waddr = slot(req_q_reg, req_task_reg);
                    pv_waddr = slot(req_q_reg, req_task_reg);
                    if (req_cnt_reg == '0)
                    begin
                        nx_wdata = req_task_reg;
                        pv_wdata = req_task_reg;
                    end
                    else
                    begin
                        nx_wdata = req_head_reg;
                        pv_wdata = pv_rdata;
                    end
                end
                else if (do_rem && (cnt_new != '0))
                begin
                    // unlink: prev of next, next of prev
                    pv_we    = 1'b1;
                    pv_waddr = slot(req_q_reg, nx_rdata);
                    pv_wdata = pv_rdata;
                    nx_we    = 1'b1;
                    nx_waddr = slot(req_q_reg, pv_rdata);
                    nx_wdata = nx_rdata;
                end
            end
            S_WR2:
            begin
                nx_we    = 1'b1;
                nx_waddr = slot(req_q_reg, tail_reg);
                nx_wdata = req_task_reg;
                pv_we    = 1'b1;
                pv_waddr = slot(req_q_reg, req_head_reg);
                pv_wdata = req_task_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign ld      = (((state_reg == S_EXEC) && !need_wr2) || (state_reg == S_WR2) ||
                      (state_reg == S_FIN)) && !stall;
    assign ld_data = (state_reg == S_EXEC) ? res_now : res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (need_wr2)
                begin
                    state_next = S_WR2;
                end
                else if (!stall)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_WR2, S_FIN:
            begin
                state_next = stall ? S_FIN : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < TASKS; i++)
            begin
                member_reg[i] <= '0;
            end
            for (int i = 0; i < QUEUES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_EXEC) && (do_ins || do_rem))
            begin
                member_reg[req_task_reg][req_q_reg] <= do_ins;
                count_reg[req_q_reg]                <= cnt_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            req_q_reg    <= req.queue_sel;
            req_task_reg <= req.task_id;
            req_qv_reg   <= in_qv;
            req_mem_reg  <= member_reg[req.task_id];
            req_cnt_reg  <= in_qv ? count_reg[req.queue_sel] : '0;
            req_head_reg <= in_head;
        end
        if (state_reg == S_EXEC)
        begin
            tail_reg <= pv_rdata;
            res_reg  <= res_now;
            if (do_ins || do_rem)
            begin
                head_reg[req_q_reg] <= head_new;
            end
        end
    end

    ctlm_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (ld),
        .data  (ld_data),
        .stall (stall),
        .rsp   (rsp)
    );

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not advance to execute");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!nx_we && !pv_we))
        else $error("link write while idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ld |-> !stall)
        else $error("result loaded over a held transfer");

    a_ins_member: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && do_ins) |=> member_reg[req_task_reg][req_q_reg])
        else $error("inserted task not marked as member");

    a_rem_member: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && do_rem) |=> !member_reg[req_task_reg][req_q_reg])
        else $error("removed task still marked as member");
endmodule

/* rtl/ctlm_ram.sv */
// ----------------------------------------------------------------------------
// ctlm_ram: generic single-write, single-read RAM
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module ctlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/ctlm_out.sv */
// ----------------------------------------------------------------------------
// ctlm_out: result output register
// Holds one finished result until the sink takes the transfer.
// ----------------------------------------------------------------------------
module ctlm_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ctlm_pkg::rsp_t      data,
    output logic                stall,
    ctlm_rsp_if.source          rsp
);
    import ctlm_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign stall = valid_reg && !rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.ok          = data_reg.ok;
    assign rsp.count_after = data_reg.count_after;
    assign rsp.head_task   = data_reg.head_task;
    assign rsp.head_valid  = data_reg.head_valid;
endmodule
